// ===== rtl/core/scrg_pkg.sv =====
// Shared types, register codes and constants for the servo command rate guard.
// No dependencies; used by scrg_decide and servo_command_rate_guard.
package scrg_pkg;

    // Block parameters (defaults)
    localparam int NUM_SERVOS_DEF = 2;
    localparam int PWM_WRAP_DEF   = 19999;

    // Field widths
    localparam int ANGLE_W = 8;
    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 15;
    localparam int COUNT_W = 8;
    localparam int US_W    = 26;   // 65535 ms in microseconds fits in 26 bits
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int US_PER_MS = 1000;

    // Config reset values (ms, counts, degrees)
    localparam int CFG_MIN_INTERVAL_RST = 250;
    localparam int CFG_WINDOW_LEN_RST   = 1200;
    localparam int CFG_WINDOW_LIMIT_RST = 5;
    localparam int CFG_COOLDOWN_RST     = 2000;
    localparam int CFG_INIT_ANGLE_RST   = 0;

    // Pulse mapping: 500 us + angle * 2000 us / 180, 20 ms period
    localparam int ANGLE_MAX  = 180;
    localparam int PULSE_BASE = 500;
    localparam int PULSE_SPAN = 2000;
    localparam int FRAME_US   = 20000;
    localparam longint unsigned PULSE_DEN = longint'(ANGLE_MAX) * longint'(FRAME_US);

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_MIN_INTERVAL = 3'd0;
    localparam t_cfg_index CFG_WINDOW_LEN   = 3'd1;
    localparam t_cfg_index CFG_WINDOW_LIMIT = 3'd2;
    localparam t_cfg_index CFG_COOLDOWN     = 3'd3;
    localparam t_cfg_index CFG_INIT_ANGLE   = 3'd4;

    typedef enum logic [1:0] {
        OUTCOME_DONE    = 2'd0,
        OUTCOME_SKIPPED = 2'd1,
        OUTCOME_BLOCKED = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_COOLDOWN = 2'd1,
        CAUSE_INTERVAL = 2'd2,
        CAUSE_WINDOW   = 2'd3
    } t_cause;

    typedef struct packed {
        logic               servo_select;
        logic [ANGLE_W-1:0] cmd_angle;
        logic [TIME_W-1:0]  now_us;
    } t_in_word;

    typedef struct packed {
        t_outcome           outcome;
        t_cause             block_cause;
        logic               pwm_valid;
        logic [LEVEL_W-1:0] pwm_level;
    } t_out_word;

    // Config held pre-scaled to microseconds
    typedef struct packed {
        logic [US_W-1:0]    min_interval_us;
        logic [US_W-1:0]    window_len_us;
        logic [COUNT_W-1:0] window_limit;
        logic [US_W-1:0]    cooldown_us;
        logic [ANGLE_W-1:0] initial_angle;
    } t_cfg;

    // Per-servo guard state (ready flag kept separately, it needs reset)
    typedef struct packed {
        logic [ANGLE_W-1:0] current_angle;
        logic               last_valid;
        logic [TIME_W-1:0]  last_time;
        logic [TIME_W-1:0]  window_start;
        logic [TIME_W-1:0]  lockout_end;
        logic [COUNT_W-1:0] window_count;
    } t_guard;

    typedef logic [LEVEL_W-1:0] t_pwm_tab [ANGLE_MAX+1];

    // Compare level per clamped angle, evaluated at elaboration
    function automatic t_pwm_tab pwm_table(input int unsigned wrap);
        t_pwm_tab          tab;
        longint unsigned   num;
        longint unsigned   lvl;
        for (int a = 0; a <= ANGLE_MAX; a++) begin
            num = (longint'(PULSE_BASE) * longint'(ANGLE_MAX)
                   + longint'(a) * longint'(PULSE_SPAN)) * (longint'(wrap) + 64'd1);
            lvl = num / PULSE_DEN;
            if (lvl > longint'(wrap)) begin
                lvl = longint'(wrap);
            end
            tab[a] = lvl[LEVEL_W-1:0];
        end
        return tab;
    endfunction

endpackage

// ===== rtl/core/scrg_decide.sv =====
// Single-pass guard decision for one command against one servo's state.
// Depends on scrg_pkg (types, constants, pulse table).
module scrg_decide #(
    parameter int PWM_WRAP = scrg_pkg::PWM_WRAP_DEF
) (
    input  scrg_pkg::t_in_word  i_word,
    input  logic                i_present,
    input  logic                i_ready,
    input  scrg_pkg::t_guard    i_guard,
    input  scrg_pkg::t_cfg      i_cfg,
    output scrg_pkg::t_out_word o_result,
    output scrg_pkg::t_guard    o_guard_next
);

    localparam scrg_pkg::t_pwm_tab PWM_TAB = scrg_pkg::pwm_table(PWM_WRAP);

    scrg_pkg::t_guard                  g;
    logic [scrg_pkg::TIME_W-1:0]       d_lock;
    logic [scrg_pkg::TIME_W-1:0]       d_last;
    logic [scrg_pkg::TIME_W-1:0]       d_win;
    logic [scrg_pkg::COUNT_W-1:0]      cnt;
    logic [scrg_pkg::COUNT_W-1:0]      cnt_inc;
    logic [scrg_pkg::ANGLE_W-1:0]      angle_clamped;
    logic                              cooldown_active;

    assign angle_clamped = (i_word.cmd_angle > scrg_pkg::ANGLE_W'(scrg_pkg::ANGLE_MAX))
                         ? scrg_pkg::ANGLE_W'(scrg_pkg::ANGLE_MAX) : i_word.cmd_angle;

    always_comb begin
        // first command to this servo sets the guard up before any check
        g = i_guard;
        if (!i_ready) begin
            g.current_angle = i_cfg.initial_angle;
            g.last_valid    = 1'b0;
            g.window_start  = i_word.now_us;
            g.lockout_end   = i_word.now_us;
            g.window_count  = '0;
        end

        d_lock = g.lockout_end - i_word.now_us;
        d_last = i_word.now_us - g.last_time;
        d_win  = i_word.now_us - g.window_start;
        cooldown_active = !d_lock[scrg_pkg::TIME_W-1] && (d_lock != '0);

        o_result.outcome     = scrg_pkg::OUTCOME_BLOCKED;
        o_result.block_cause = scrg_pkg::CAUSE_NONE;
        o_result.pwm_valid   = 1'b0;
        o_result.pwm_level   = '0;
        o_guard_next         = g;
        cnt                  = g.window_count;
        cnt_inc              = g.window_count;

        if (!i_present) begin
            o_result.block_cause = scrg_pkg::CAUSE_NONE;
        end else if (cooldown_active) begin
            o_result.block_cause = scrg_pkg::CAUSE_COOLDOWN;
        end else if (i_word.cmd_angle == g.current_angle) begin
            o_result.outcome = scrg_pkg::OUTCOME_SKIPPED;
        end else if (g.last_valid &&
                     ($signed(d_last) < $signed(32'(i_cfg.min_interval_us)))) begin
            o_result.block_cause = scrg_pkg::CAUSE_INTERVAL;
        end else begin
            // stale window restarts at this command
            if ($signed(d_win) > $signed(32'(i_cfg.window_len_us))) begin
                o_guard_next.window_start = i_word.now_us;
                cnt = '0;
            end
            cnt_inc = (cnt == '1) ? cnt : cnt + 1'b1;
            o_guard_next.window_count = cnt_inc;
            if (cnt_inc > i_cfg.window_limit) begin
                o_guard_next.lockout_end = i_word.now_us + 32'(i_cfg.cooldown_us);
                o_result.block_cause = scrg_pkg::CAUSE_WINDOW;
            end else begin
                o_guard_next.current_angle = i_word.cmd_angle;
                o_guard_next.last_time     = i_word.now_us;
                o_guard_next.last_valid    = 1'b1;
                o_result.outcome   = scrg_pkg::OUTCOME_DONE;
                o_result.pwm_valid = 1'b1;
                o_result.pwm_level = PWM_TAB[angle_clamped];
            end
        end
    end

endmodule

// ===== rtl/core/servo_command_rate_guard.sv =====
// Top level of the servo command rate guard: handshakes, config, guard state.
// Depends on scrg_pkg and scrg_decide.
//
// Rate guard in front of NUM_SERVOS servos. Each input word is an angle command
// stamped with a wrapping microsecond time; each produces exactly one result word
// (done with a PWM compare level, skipped as same angle, or blocked with a cause).
// The result word is registered: one input register, the guard decision, one
// result register. One word per cycle is sustained while the output is ready; the
// limit is the read-decide-write loop on the addressed servo's state registers,
// which is combinational, so back-to-back commands to the same servo see
// each other's updates. Timing config (ms) is scaled to microseconds when written;
// write config only while no word is in flight.
module servo_command_rate_guard #(
    parameter int NUM_SERVOS = scrg_pkg::NUM_SERVOS_DEF,
    parameter int PWM_WRAP   = scrg_pkg::PWM_WRAP_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  scrg_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output scrg_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  scrg_pkg::t_cfg_index                i_cfg_index,
    input  logic [scrg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

    scrg_pkg::t_in_word   r_in;
    logic                 r_in_valid;
    logic                 n_in_valid;
    scrg_pkg::t_out_word  r_out;
    logic                 r_out_valid;
    logic                 n_out_valid;
    scrg_pkg::t_cfg       r_cfg;

    scrg_pkg::t_guard     r_guard [NUM_SERVOS];
    logic [NUM_SERVOS-1:0] r_guard_ready;

    logic                 advance;
    logic                 in_take;
    logic                 present;
    logic [IDX_W-1:0]     idx;
    scrg_pkg::t_guard     guard_cur;
    scrg_pkg::t_guard     guard_next;
    scrg_pkg::t_out_word  result;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign present   = 32'(r_in.servo_select) < 32'(NUM_SERVOS);
    assign idx       = IDX_W'(r_in.servo_select);
    assign guard_cur = present ? r_guard[idx] : '0;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    scrg_decide #(
        .PWM_WRAP (PWM_WRAP)
    ) u_decide (
        .i_word       (r_in),
        .i_present    (present),
        .i_ready      (present && r_guard_ready[idx]),
        .i_guard      (guard_cur),
        .i_cfg        (r_cfg),
        .o_result     (result),
        .o_guard_next (guard_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_word;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    // guard state: only the ready flags need reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard_ready <= '0;
        end else if (advance && present) begin
            r_guard_ready[idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && present) begin
            r_guard[idx] <= guard_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_interval_us <= scrg_pkg::US_W'(scrg_pkg::CFG_MIN_INTERVAL_RST
                                                    * scrg_pkg::US_PER_MS);
            r_cfg.window_len_us   <= scrg_pkg::US_W'(scrg_pkg::CFG_WINDOW_LEN_RST
                                                    * scrg_pkg::US_PER_MS);
            r_cfg.window_limit    <= scrg_pkg::COUNT_W'(scrg_pkg::CFG_WINDOW_LIMIT_RST);
            r_cfg.cooldown_us     <= scrg_pkg::US_W'(scrg_pkg::CFG_COOLDOWN_RST
                                                    * scrg_pkg::US_PER_MS);
            r_cfg.initial_angle   <= scrg_pkg::ANGLE_W'(scrg_pkg::CFG_INIT_ANGLE_RST);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                scrg_pkg::CFG_MIN_INTERVAL: begin
                    r_cfg.min_interval_us <= scrg_pkg::US_W'(32'(i_cfg_data)
                                                            * scrg_pkg::US_PER_MS);
                end
                scrg_pkg::CFG_WINDOW_LEN: begin
                    r_cfg.window_len_us <= scrg_pkg::US_W'(32'(i_cfg_data)
                                                          * scrg_pkg::US_PER_MS);
                end
                scrg_pkg::CFG_WINDOW_LIMIT: begin
                    r_cfg.window_limit <= i_cfg_data[scrg_pkg::COUNT_W-1:0];
                end
                scrg_pkg::CFG_COOLDOWN: begin
                    r_cfg.cooldown_us <= scrg_pkg::US_W'(32'(i_cfg_data)
                                                        * scrg_pkg::US_PER_MS);
                end
                scrg_pkg::CFG_INIT_ANGLE: begin
                    r_cfg.initial_angle <= i_cfg_data[scrg_pkg::ANGLE_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
